// ===== rtl/ohr_pkg.sv =====
`timescale 1ns / 1ps

package ohr_pkg;

  // Ring geometry
  localparam int DEPTH    = 20;
  localparam int ID_BYTES = 8;
  localparam int PTR_W    = $clog2(DEPTH);

  // Field widths
  localparam int ID_W   = 64;
  localparam int TIME_W = 32;
  localparam int REC_W  = ID_W + 2 * TIME_W;

  // Bytes of the identifier that are kept
  localparam logic [ID_W-1:0] ID_MASK = (ID_BYTES >= 8) ? {ID_W{1'b1}} :
    ((ID_W'(1) << (8 * ID_BYTES)) - ID_W'(1));

  // Command codes carried on tuser
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_LIST = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LIST
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic add;
    logic list_start;
    logic rd_issue;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic rd_last;
    logic empty;
  } dp_status_t;

  // Ring position after p, wrapping at the depth
  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/ohr_ctrl.sv =====
`timescale 1ns / 1ps

module ohr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tuser,
  output logic                in_tready,
  input  ohr_pkg::dp_status_t status,
  output ohr_pkg::dp_cmd_t    cmd
);

  ohr_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ohr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    cmd.add        = 1'b0;
    cmd.list_start = 1'b0;
    cmd.rd_issue   = 1'b0;
    case (state_r)
      ohr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == ohr_pkg::CMD_ADD) begin
            cmd.add = 1'b1;
          end else begin
            cmd.list_start = 1'b1;
            state_nxt      = ohr_pkg::ST_LIST;
          end
        end
      end
      ohr_pkg::ST_LIST: begin
        // one read per free output slot
        if (status.slot_free) begin
          cmd.rd_issue = 1'b1;
          if (status.rd_last || status.empty) begin
            state_nxt = ohr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ohr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ohr_datapath.sv =====
`timescale 1ns / 1ps

module ohr_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ohr_pkg::dp_cmd_t                cmd,
  input  logic [ohr_pkg::ID_W-1:0]        user_id,
  input  logic [ohr_pkg::TIME_W-1:0]      start_time,
  input  logic [ohr_pkg::TIME_W-1:0]      now_time,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ohr_pkg::REC_W-1:0]       out_rec,
  output logic                            out_empty,
  output logic                            out_last,
  output ohr_pkg::dp_status_t             status
);

  logic [ohr_pkg::REC_W-1:0] mem [ohr_pkg::DEPTH];

  logic [ohr_pkg::PTR_W-1:0] oldest_ptr_r, oldest_ptr_nxt;
  logic [ohr_pkg::PTR_W-1:0] write_ptr_r, write_ptr_nxt;
  logic [ohr_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic                      empty_r, empty_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_last_r;
  logic                      out_empty_r;
  logic [ohr_pkg::REC_W-1:0] rd_data_r;
  logic                      rd_last;

  assign rd_last = (ohr_pkg::next_pos(rd_ptr_r) == write_ptr_r);

  assign status.slot_free = !out_valid_r || out_ready;
  assign status.rd_last   = rd_last;
  assign status.empty     = empty_r;

  // Pointer and flag updates
  always_comb begin
    oldest_ptr_nxt = oldest_ptr_r;
    write_ptr_nxt  = write_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    empty_nxt      = empty_r;
    if (cmd.add) begin
      // full ring: drop the oldest record
      if ((write_ptr_r == oldest_ptr_r) && !empty_r) begin
        oldest_ptr_nxt = ohr_pkg::next_pos(oldest_ptr_r);
      end
      write_ptr_nxt = ohr_pkg::next_pos(write_ptr_r);
      empty_nxt     = 1'b0;
    end
    if (cmd.list_start) begin
      rd_ptr_nxt = oldest_ptr_r;
    end else if (cmd.rd_issue) begin
      rd_ptr_nxt = ohr_pkg::next_pos(rd_ptr_r);
    end
  end

  // Output slot valid
  always_comb begin
    if (cmd.rd_issue) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_ptr_r <= '0;
      write_ptr_r  <= '0;
      rd_ptr_r     <= '0;
      empty_r      <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      oldest_ptr_r <= oldest_ptr_nxt;
      write_ptr_r  <= write_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      empty_r      <= empty_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Record memory, registered read straight into the output slot
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      mem[write_ptr_r] <= {now_time, start_time, user_id & ohr_pkg::ID_MASK};
    end
    if (cmd.rd_issue) begin
      rd_data_r   <= empty_r ? '0 : mem[rd_ptr_r];
      out_empty_r <= empty_r;
      out_last_r  <= empty_r || rd_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = rd_data_r;
  assign out_empty = out_empty_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_empty_ptrs_equal: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (oldest_ptr_r == write_ptr_r))
    else $error("empty ring with differing pointers");

  a_add_clears_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add |=> !empty_r)
    else $error("ring still empty after add");

  a_empty_read_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_issue && empty_r) |=> (out_valid_r && out_empty_r && out_last_r))
    else $error("empty listing not flagged");

  a_no_read_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (!out_valid_r || out_ready))
    else $error("read issued into occupied output slot");
`endif

endmodule

// ===== rtl/overwriting_history_ring_core.sv =====
`timescale 1ns / 1ps
// Add: accepted whenever in_tready is high, produces no result; adds can follow back to back.
// List: on accept the controller enters its list state and issues reads into
// the registered output slot, one result per cycle while out_tready is high;
// the input stays blocked until the final read is issued (single memory read port).
// Reset (synchronous, rst_n low): ring empty, pointers zero; record memory is not cleared.

module overwriting_history_ring_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // user_id[63:0], start_time[95:64], now_time[127:96]
  input  logic         in_tuser,  // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata, // rec_id[63:0], rec_login[95:64], rec_logout[127:96]
  output logic         out_tuser, // is_empty
  output logic         out_tlast
);

  ohr_pkg::dp_cmd_t    dp_cmd;
  ohr_pkg::dp_status_t dp_status;

  ohr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  ohr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .user_id    (in_tdata[63:0]),
    .start_time (in_tdata[95:64]),
    .now_time   (in_tdata[127:96]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_rec    (out_tdata),
    .out_empty  (out_tuser),
    .out_last   (out_tlast),
    .status     (dp_status)
  );

endmodule
